// File: hdl/rpib_pkg.sv
// Shared types and constants for the RGBA palette index builder.
package rpib_pkg;

    localparam int PALETTE_ENTRIES_DEF = 64;
    localparam int COLOR_W             = 32;
    localparam int COUNT_W             = 7;
    localparam int INDEX_W             = 8;
    localparam logic [INDEX_W-1:0] CODE_NONE = 8'hFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } rpib_state_t;

endpackage

// File: hdl/rgba_palette_index_builder_core.sv
// Top level of the RGBA palette index builder: sequencer, search compare and result register.
//
// Pixels enter on the input channel (in_valid / in_stall) with fields new_image, red,
// green, blue and alpha. One result per pixel leaves on the output channel
// (out_valid / out_stall) with index, added, overflow and color_count.
// A transfer happens at a rising edge where valid is high and stall is low.
//
// The block handles one pixel at a time and holds in_stall high from the transfer
// until the result is loaded into the output register. A transparent pixel goes
// straight to the emit state without a search. An opaque pixel reads the palette
// memory one entry per cycle in insertion order and compares each entry in the
// cycle after its read, over all entries of a full palette of 64 if none matches;
// its result is then loaded from the emit state, and the next pixel is taken once
// the block is back in idle. A match ends the scan early.
//
// If the receiver stalls, the result waits in the output register; the next pixel
// is already taken and searched, and its result waits until the register frees.
// Reset empties the palette and the output register; palette memory contents are
// never read before being written, so the memory needs no clearing pass.
module rgba_palette_index_builder_core
    import rpib_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               new_image,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic [7:0]         alpha,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] index,
    output logic               added,
    output logic               overflow,
    output logic [COUNT_W-1:0] color_count
);

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [COUNT_W-1:0] CAPACITY = COUNT_W'(PALETTE_ENTRIES);

    rpib_state_t        state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0]   cmp_pos_reg, cmp_pos_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [COLOR_W-1:0] color_reg, color_next;

    logic [INDEX_W-1:0] res_index_reg, res_index_next;
    logic               res_added_reg, res_added_next;
    logic               res_overflow_reg, res_overflow_next;

    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic               out_added_reg, out_added_next;
    logic               out_overflow_reg, out_overflow_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    logic               wr_en;
    logic               rd_en;
    logic [COLOR_W-1:0] rd_data;
    logic               hit;

    rpib_palette_ram #(
        .DEPTH  (PALETTE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (color_reg),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign hit = cmp_valid_reg && (rd_data == color_reg);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        ptr_next          = ptr_reg;
        cmp_pos_next      = cmp_pos_reg;
        cmp_valid_next    = 1'b0;
        color_next        = color_reg;
        res_index_next    = res_index_reg;
        res_added_next    = res_added_reg;
        res_overflow_next = res_overflow_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_index_next    = out_index_reg;
        out_added_next    = out_added_reg;
        out_overflow_next = out_overflow_reg;
        out_count_next    = out_count_reg;
        wr_en             = 1'b0;
        rd_en             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    color_next = {red, green, blue, alpha};
                    ptr_next   = '0;
                    if (new_image)
                    begin
                        count_next = '0;
                    end
                    if (alpha == 8'd0)
                    begin
                        res_index_next    = CODE_NONE;
                        res_added_next    = 1'b0;
                        res_overflow_next = 1'b0;
                        state_next        = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    res_index_next    = INDEX_W'({cmp_pos_reg, 2'b00});
                    res_added_next    = 1'b0;
                    res_overflow_next = 1'b0;
                    state_next        = ST_EMIT;
                end
                else if (ptr_reg < count_reg)
                begin
                    // Issue the next read; its data is compared in the following cycle.
                    rd_en          = 1'b1;
                    cmp_pos_next   = ptr_reg[IDX_W-1:0];
                    cmp_valid_next = 1'b1;
                    ptr_next       = ptr_reg + COUNT_W'(1);
                end
                else if (count_reg >= CAPACITY)
                begin
                    res_index_next    = CODE_NONE;
                    res_added_next    = 1'b0;
                    res_overflow_next = 1'b1;
                    state_next        = ST_EMIT;
                end
                else
                begin
                    wr_en             = 1'b1;
                    count_next        = count_reg + COUNT_W'(1);
                    res_index_next    = INDEX_W'({count_reg[IDX_W-1:0], 2'b00});
                    res_added_next    = 1'b1;
                    res_overflow_next = 1'b0;
                    state_next        = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    out_index_next    = res_index_reg;
                    out_added_next    = res_added_reg;
                    out_overflow_next = res_overflow_reg;
                    out_count_next    = count_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_pos_reg      <= cmp_pos_next;
        color_reg        <= color_next;
        res_index_reg    <= res_index_next;
        res_added_reg    <= res_added_next;
        res_overflow_reg <= res_overflow_next;
        out_index_reg    <= out_index_next;
        out_added_reg    <= out_added_next;
        out_overflow_reg <= out_overflow_next;
        out_count_reg    <= out_count_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign index       = out_index_reg;
    assign added       = out_added_reg;
    assign overflow    = out_overflow_reg;
    assign color_count = out_count_reg;

    // A pixel transfer always starts a busy period.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a pixel transfer");

    // The palette never holds more entries than it has room for.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAPACITY)
        else $error("palette entry count beyond capacity");

    // An appended color sits at the last entry of the palette.
    a_added_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && added) |->
            (!overflow && index == INDEX_W'({color_count - COUNT_W'(1), 2'b00})))
        else $error("added entry offset does not match the entry count");

    // Overflow is reported only with a full palette and the no-entry code.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |-> (color_count == CAPACITY && index == CODE_NONE))
        else $error("overflow reported without a full palette");

endmodule

// File: hdl/rpib_palette_ram.sv
// Palette storage: one write port and one read port with registered read data.
module rpib_palette_ram
    import rpib_pkg::*;
#(
    parameter int DEPTH  = PALETTE_ENTRIES_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [COLOR_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [COLOR_W-1:0] rd_data
);

    logic [COLOR_W-1:0] mem [DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
